// ===== design/s3tc_pkg.sv =====
package s3tc_pkg;

    // block format codes
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_FORMAT = 1'b0;

    typedef struct packed {
        logic [63:0] alpha_bits;
        logic [63:0] color_bits;
    } s3tc_in_t;

    typedef struct packed {
        logic [1:0]  row_number;
        logic [31:0] texel_zero;
        logic [31:0] texel_one;
        logic [31:0] texel_two;
        logic [31:0] texel_three;
        logic        last_row;
    } s3tc_out_t;

    // floor(v*255/31) = 8v + floor(7v/31), the quotient by reciprocal multiply
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  v7;
        logic [17:0] prod;
        v7   = {v, 3'b000} - {3'b000, v};
        prod = 18'(v7) * 18'd529;
        return {v, 3'b000} + {5'd0, prod[16:14]};
    endfunction

    // floor(g*255/63) = 4g + floor(g/21)
    function automatic logic [7:0] expand6(input logic [5:0] g);
        logic [1:0] q;
        if (g >= 6'd63)
            q = 2'd3;
        else if (g >= 6'd42)
            q = 2'd2;
        else if (g >= 6'd21)
            q = 2'd1;
        else
            q = 2'd0;
        return {g, 2'b00} + {6'd0, q};
    endfunction

    // floor(x/3) for x up to 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd683;
        return prod[18:11];
    endfunction

    // floor(x/5) for x up to 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd3277;
        return prod[21:14];
    endfunction

    // floor(x/7) for x up to 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd2341;
        return prod[21:14];
    endfunction

endpackage

// ===== design/s3tc_block_decoder.sv =====
// S3TC block decoder (DXT1, DXT3, DXT5)
//
// Input channel: one compressed 4x4 block (alpha half and colour half) is
// taken at a rising edge where start is high and busy is low. The block is
// held in an input register while the four texel rows are decoded, one row
// per cycle, into a result register.
// Result channel: result_valid marks a row result for exactly one cycle;
// rows come in order 0..3 on consecutive cycles and row 3 has last_row set.
// The receiver cannot stall, so nothing waits on the output side.
// Each row is decoded combinationally from the input register and held in the result register.
// Blocks: the single row decoder is shared by the four rows, so a new
// block waits for the current one; busy drops while row 3 is decoded so
// the next block enters right behind the current one.
// Configuration: block_format at APB byte address 0 (0 DXT1, 1 DXT3,
// 2 DXT5, 3 decodes as DXT5), to be written only while idle, which the
// block does not enforce; it is sampled with each accepted block.
// Reset: rst_n clears the row sequencer, result_valid and block_format.
module s3tc_block_decoder
    import s3tc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  s3tc_in_t    item,
    output logic        result_valid,
    output s3tc_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  format_cfg_reg;
    logic [1:0]  format_reg;
    s3tc_in_t    item_reg;
    logic        active_reg;
    logic [1:0]  row_reg;
    logic        result_valid_reg;
    s3tc_out_t   result_reg;
    s3tc_out_t   result_next;
    logic        accept;
    logic        cfg_write;

    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic        three_mode;
    logic [7:0]  pal_r [4];
    logic [7:0]  pal_g [4];
    logic [7:0]  pal_b [4];
    logic [7:0]  pal_a [4];
    logic [7:0]  apal  [8];
    logic [31:0] texel [4];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_BLOCK_FORMAT) ? {30'd0, format_cfg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_cfg_reg <= FMT_DXT1;
        else if (cfg_write && paddr[2] == REG_BLOCK_FORMAT)
            format_cfg_reg <= pwdata[1:0];
    end

    // input handshake
    assign busy   = active_reg && (row_reg != 2'd3);
    assign accept = start && !busy;

    // input register, sampled with the format
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= item;
            format_reg <= format_cfg_reg;
        end
    end

    // row sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            row_reg    <= 2'd0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            row_reg    <= 2'd0;
        end
        else if (active_reg)
        begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == 2'd3)
                active_reg <= 1'b0;
        end
    end

    // colour palette
    assign c0 = item_reg.color_bits[15:0];
    assign c1 = item_reg.color_bits[31:16];
    assign three_mode = (format_reg == FMT_DXT1) && (c0 <= c1);

    always_comb
    begin
        pal_r[0] = expand5(c0[15:11]);
        pal_g[0] = expand6(c0[10:5]);
        pal_b[0] = expand5(c0[4:0]);
        pal_r[1] = expand5(c1[15:11]);
        pal_g[1] = expand6(c1[10:5]);
        pal_b[1] = expand5(c1[4:0]);
        pal_a[0] = 8'd255;
        pal_a[1] = 8'd255;
        pal_a[2] = 8'd255;
        if (three_mode)
        begin
            pal_r[2] = 8'((9'(pal_r[0]) + 9'(pal_r[1])) >> 1);
            pal_g[2] = 8'((9'(pal_g[0]) + 9'(pal_g[1])) >> 1);
            pal_b[2] = 8'((9'(pal_b[0]) + 9'(pal_b[1])) >> 1);
            pal_r[3] = 8'd0;
            pal_g[3] = 8'd0;
            pal_b[3] = 8'd0;
            pal_a[3] = 8'd0;
        end
        else
        begin
            pal_r[2] = div3({1'b0, pal_r[0], 1'b0} + 10'(pal_r[1]));
            pal_g[2] = div3({1'b0, pal_g[0], 1'b0} + 10'(pal_g[1]));
            pal_b[2] = div3({1'b0, pal_b[0], 1'b0} + 10'(pal_b[1]));
            pal_r[3] = div3(10'(pal_r[0]) + {1'b0, pal_r[1], 1'b0});
            pal_g[3] = div3(10'(pal_g[0]) + {1'b0, pal_g[1], 1'b0});
            pal_b[3] = div3(10'(pal_b[0]) + {1'b0, pal_b[1], 1'b0});
            pal_a[3] = 8'd255;
        end
    end

    // interpolated alpha palette
    assign a0 = item_reg.alpha_bits[7:0];
    assign a1 = item_reg.alpha_bits[15:8];

    always_comb
    begin
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1)
        begin
            for (int s = 1; s <= 6; s++)
                apal[s + 1] = div7(11'(7 - s) * 11'(a0) + 11'(s) * 11'(a1));
        end
        else
        begin
            for (int s = 1; s <= 4; s++)
                apal[s + 1] = div5(11'(5 - s) * 11'(a0) + 11'(s) * 11'(a1));
            apal[6] = 8'd0;
            apal[7] = 8'd255;
        end
    end

    // texels of the current row
    always_comb
    begin
        for (int col = 0; col < 4; col++)
        begin
            logic [3:0] t;
            logic [1:0] ci;
            logic [3:0] a4;
            logic [2:0] ai;
            logic [7:0] alpha;
            t  = {row_reg, 2'(col)};
            ci = item_reg.color_bits[32 + 2 * t +: 2];
            a4 = item_reg.alpha_bits[4 * t +: 4];
            ai = item_reg.alpha_bits[16 + 3 * t +: 3];
            case (format_reg)
                FMT_DXT1: alpha = pal_a[ci];
                FMT_DXT3: alpha = {a4, a4};
                default:  alpha = apal[ai];
            endcase
            texel[col] = {alpha, pal_b[ci], pal_g[ci], pal_r[ci]};
        end
    end

    always_comb
    begin
        result_next.row_number  = row_reg;
        result_next.texel_zero  = texel[0];
        result_next.texel_one   = texel[1];
        result_next.texel_two   = texel[2];
        result_next.texel_three = texel[3];
        result_next.last_row    = (row_reg == 2'd3);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_last_row_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_row == (result.row_number == 2'd3)))
        else $error("last_row does not match row 3");

    a_first_row_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 (result_valid && result.row_number == 2'd0))
        else $error("row 0 missing two cycles after accept");

    a_rows_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_row) |=>
            (result_valid && result.row_number == $past(result.row_number) + 2'd1))
        else $error("row results not consecutive");

    a_busy_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && row_reg == 2'd3 && !accept) |=> !active_reg && !busy)
        else $error("sequencer did not return to idle after row 3");

endmodule

// ===== dv/tb_s3tc_block_decoder.sv =====
`timescale 1ns / 1ps

module tb_s3tc_block_decoder;
    import s3tc_pkg::*;

    // format code with no name in the package, decodes as dxt5
    localparam logic [1:0] FMT_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_BLOCK_FORMAT = {REG_BLOCK_FORMAT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = {~REG_BLOCK_FORMAT, 2'b00};
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int BLOCKS_PER_PHASE = 62;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    s3tc_in_t    item;
    logic        result_valid;
    s3tc_out_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the format register and rows still to come out
    logic [1:0]  cur_format;
    s3tc_out_t   pending_rows[$];
    s3tc_out_t   row_want;
    int          error_count;
    int          rows_checked;
    int          fmt_blocks[4];
    int          cycle_count;

    s3tc_block_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
                     pending_rows.size());
            $display("** s3tc_block_decoder: FAILED **");
            $finish;
        end
    end

    // decode one block into its four expected row transactions
    function automatic void decode_block(input s3tc_in_t blk);
        int unsigned c0, c1, a0, a1, ci, alpha, t;
        int unsigned pr[4], pg[4], pb[4], pa[4];
        int unsigned apal[8];
        logic [31:0] cidx;
        logic [31:0] tex[4];
        bit          three_color;
        s3tc_out_t   row;
        c0 = 32'(blk.color_bits[15:0]);
        c1 = 32'(blk.color_bits[31:16]);
        cidx = blk.color_bits[63:32];

        // rgb565 endpoint expansion
        pr[0] = ((c0 & 32'hF800) >> 8) * 255 / 248;
        pg[0] = ((c0 & 32'h07E0) >> 3) * 255 / 252;
        pb[0] = ((c0 & 32'h001F) << 3) * 255 / 248;
        pr[1] = ((c1 & 32'hF800) >> 8) * 255 / 248;
        pg[1] = ((c1 & 32'h07E0) >> 3) * 255 / 252;
        pb[1] = ((c1 & 32'h001F) << 3) * 255 / 248;
        pa[0] = 255;
        pa[1] = 255;
        pa[2] = 255;

        // only dxt1 switches to midpoint plus transparent black
        three_color = (cur_format == FMT_DXT1) && (c0 <= c1);
        if (three_color)
        begin
            pr[2] = (pr[0] + pr[1]) / 2;
            pg[2] = (pg[0] + pg[1]) / 2;
            pb[2] = (pb[0] + pb[1]) / 2;
            pr[3] = 0;
            pg[3] = 0;
            pb[3] = 0;
            pa[3] = 0;
        end
        else
        begin
            pr[2] = (2 * pr[0] + pr[1]) / 3;
            pg[2] = (2 * pg[0] + pg[1]) / 3;
            pb[2] = (2 * pb[0] + pb[1]) / 3;
            pr[3] = (pr[0] + 2 * pr[1]) / 3;
            pg[3] = (pg[0] + 2 * pg[1]) / 3;
            pb[3] = (pb[0] + 2 * pb[1]) / 3;
            pa[3] = 255;
        end

        // dxt5 alpha palette, sevenths or fifths with 0 and 255
        a0 = 32'(blk.alpha_bits[7:0]);
        a1 = 32'(blk.alpha_bits[15:8]);
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1)
        begin
            for (int s = 1; s <= 6; s++)
                apal[s + 1] = ((7 - s) * a0 + s * a1) / 7;
        end
        else
        begin
            for (int s = 1; s <= 4; s++)
                apal[s + 1] = ((5 - s) * a0 + s * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        for (int k = 0; k < 4; k++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                t = 4 * k + col;
                ci = (cidx >> (2 * t)) & 32'h3;
                if (cur_format == FMT_DXT1)
                    alpha = pa[ci];
                else if (cur_format == FMT_DXT3)
                    alpha = 32'((blk.alpha_bits >> (4 * t)) & 64'hF) * 17;
                else
                    alpha = apal[32'((blk.alpha_bits >> (16 + 3 * t)) & 64'h7)];
                tex[col] = {alpha[7:0], pb[ci][7:0], pg[ci][7:0], pr[ci][7:0]};
            end
            row.row_number = k[1:0];
            row.texel_zero = tex[0];
            row.texel_one = tex[1];
            row.texel_two = tex[2];
            row.texel_three = tex[3];
            row.last_row = (k == 3);
            pending_rows.push_back(row);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // compare each row transaction with the oldest expected row
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected row transaction, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                row_want = pending_rows.pop_front();
                rows_checked++;
                check_field("row_number", 32'(row_want.row_number), 32'(result.row_number));
                check_field("texel_zero", row_want.texel_zero, result.texel_zero);
                check_field("texel_one", row_want.texel_one, result.texel_one);
                check_field("texel_two", row_want.texel_two, result.texel_two);
                check_field("texel_three", row_want.texel_three, result.texel_three);
                check_field("last_row", 32'(row_want.last_row), 32'(result.last_row));
            end
        end
    end

    // random idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // send one block after an idle gap; called and returns just after a falling edge
    task automatic send_block(input s3tc_in_t blk, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        decode_block(blk);
        fmt_blocks[cur_format]++;
        @(negedge clk);
    endtask

    // stop sending and wait until every expected row has come out
    task automatic drain;
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[2] == REG_BLOCK_FORMAT)
            cur_format = data[1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read_format;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_BLOCK_FORMAT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("block_format readback", {30'd0, cur_format}, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write the format register with junk in the upper bits, then read it back
    task automatic program_format(input logic [1:0] fmt);
        apb_write(ADDR_BLOCK_FORMAT, {30'($urandom_range(0, 32'h3FFF_FFFF)), fmt});
        apb_read_format();
    endtask

    // reset value, then a write to an unmapped address must leave the register alone, then one block
    task automatic test_register_access;
        apb_read_format();
        apb_write(ADDR_UNMAPPED, {30'd0, FMT_DXT5});
        apb_read_format();
        send_block({64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_0000_FFFF}, 0);
        drain();
    endtask

    // dxt1: four-colour and three-colour palettes, equal endpoints, extremes
    task automatic test_dxt1;
        program_format(FMT_DXT1);
        send_block({{$urandom, $urandom}, 64'hE4E4_E4E4_0000_FFFF}, 0);
        send_block({{$urandom, $urandom}, 64'hE4E4_E4E4_FFFF_0000}, 0);
        send_block({64'd0, 64'h1B1B_1B1B_8410_8410}, 1);
        send_block({64'd0, {$urandom, 32'h07E0_F800}}, 0);
        send_block({64'd0, {$urandom, 32'hF800_001F}}, 2);
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 0);
        send_block({64'd0, 64'd0}, 0);
        drain();
    endtask

    // dxt3: explicit alpha nibbles, colour always in thirds
    task automatic test_dxt3;
        program_format(FMT_DXT3);
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hE4E4_E4E4_FFFF_0000}, 0);
        send_block({64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_0000_FFFF}, 0);
        send_block({64'd0, {$urandom, $urandom}}, 3);
        drain();
    endtask

    // dxt5: sevenths, fifths, equal endpoints, every palette index
    task automatic test_dxt5;
        logic [63:0] idx_bits;
        idx_bits = 64'd0;
        for (int t = 0; t < 16; t++)
            idx_bits = idx_bits | (64'(t % 8) << (16 + 3 * t));
        program_format(FMT_DXT5);
        send_block({idx_bits | 64'h00FF, 64'hE4E4_E4E4_0000_FFFF}, 0);
        send_block({idx_bits | 64'hFF00, 64'hE4E4_E4E4_FFFF_0000}, 0);
        send_block({idx_bits | 64'h8080, {$urandom, $urandom}}, 0);
        send_block({idx_bits | 64'h3A97, {$urandom, $urandom}}, 1);
        send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 0);
        drain();
    endtask

    // unused code 3 behaves as dxt5
    task automatic test_unused_format;
        apb_write(ADDR_BLOCK_FORMAT, 32'hFFFF_FFFF);
        apb_read_format();
        send_block({{$urandom, $urandom}, {$urandom, $urandom}}, 0);
        send_block({{16'($urandom), $urandom, 16'h10F0}, {$urandom, 32'h0000_FFFF}}, 0);
        drain();
    endtask

    // random blocks over several formats, shaped toward palette corner cases
    task automatic test_random_blocks;
        logic [1:0]  phase_fmt[RANDOM_PHASES];
        logic [15:0] endpoints[5];
        logic [15:0] c0, c1, tmp;
        logic [7:0]  a0, a1, atmp;
        s3tc_in_t    blk;
        bit          quiet;
        int          pause_at;
        phase_fmt = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_UNUSED,
                      FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_DXT1};
        endpoints = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
        quiet = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_format(phase_fmt[p]);
            pause_at = $urandom_range(10, BLOCKS_PER_PHASE - 10);
            for (int i = 0; i < BLOCKS_PER_PHASE; i++)
            begin
                if (i % 20 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                // sender holds off until every pending row has come out
                if (i == pause_at)
                    drain();
                blk.alpha_bits = {$urandom, $urandom};
                blk.color_bits = {$urandom, $urandom};
                c0 = blk.color_bits[15:0];
                c1 = blk.color_bits[31:16];
                a0 = blk.alpha_bits[7:0];
                a1 = blk.alpha_bits[15:8];
                case ($urandom_range(0, 9))
                    4, 5:
                    begin
                        if (c0 > c1)
                        begin
                            tmp = c0;
                            c0 = c1;
                            c1 = tmp;
                        end
                    end
                    6: c1 = c0;
                    7:
                    begin
                        if ($urandom_range(0, 1))
                            a1 = a0;
                        else if (a0 > a1)
                        begin
                            atmp = a0;
                            a0 = a1;
                            a1 = atmp;
                        end
                    end
                    8:
                    begin
                        c0 = endpoints[$urandom_range(0, 4)];
                        c1 = endpoints[$urandom_range(0, 4)];
                        a0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        a1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                    9:
                    begin
                        if (a0 < a1)
                        begin
                            atmp = a0;
                            a0 = a1;
                            a1 = atmp;
                        end
                    end
                    default: ;
                endcase
                blk.color_bits[31:0] = {c1, c0};
                blk.alpha_bits[15:0] = {a1, a0};
                send_block(blk, pick_gap(quiet));
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_format = FMT_DXT1;
        error_count = 0;
        rows_checked = 0;
        cycle_count = 0;
        fmt_blocks = '{0, 0, 0, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_register_access();
        test_dxt1();
        test_dxt3();
        test_dxt5();
        test_unused_format();
        test_random_blocks();

        $display("blocks decoded: dxt1 %0d, dxt3 %0d, dxt5 %0d, unused code %0d",
                 fmt_blocks[FMT_DXT1], fmt_blocks[FMT_DXT3], fmt_blocks[FMT_DXT5],
                 fmt_blocks[FMT_UNUSED]);
        $display("row transactions checked: %0d, mismatches: %0d, cycles: %0d",
                 rows_checked, error_count, cycle_count);
        if (error_count == 0 && pending_rows.size() == 0)
            $display("** s3tc_block_decoder: PASSED **");
        else
            $display("** s3tc_block_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/s3tc_pkg.sv
design/s3tc_block_decoder.sv
dv/tb_s3tc_block_decoder.sv
